// File: src/labs_pkg.sv
package labs_pkg;

    localparam int NUM_CHANNELS = 7;
    localparam int NUM_PRESETS  = 6;
    localparam int CH_W         = $clog2(NUM_CHANNELS);
    localparam int PR_W         = $clog2(NUM_PRESETS + 1);

    localparam logic [15:0] RATE_MIN = 16'd256;
    localparam logic [15:0] RATE_MAX = 16'd32768;
    localparam logic [3:0]  FRAC_MIN = 4'd2;
    localparam logic [3:0]  FRAC_MAX = 4'd15;
    localparam logic [3:0]  FRAC_RST = 4'd10;

    localparam logic [1:0] OP_RELOAD = 2'd0;
    localparam logic [1:0] OP_TICK   = 2'd1;
    localparam logic [1:0] OP_EVAL   = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] CFG_MAX_BW  = 2'd0;
    localparam logic [1:0] CFG_PERIOD  = 2'd1;
    localparam logic [1:0] CFG_TIGHTEN = 2'd2;
    localparam logic [1:0] CFG_EASE    = 2'd3;

    function automatic logic [15:0] preset_val(input logic [PR_W-1:0] p,
                                               input logic [CH_W-1:0] c);
        logic [15:0] row [NUM_CHANNELS];
        case (p)
            3'd0: row = '{16'd5, 16'd10, 16'd3, 16'd3, 16'd10, 16'd10, 16'd9};
            3'd1: row = '{16'd30, 16'd40, 16'd9, 16'd9, 16'd86, 16'd86, 16'd40};
            3'd2: row = '{16'd50, 16'd70, 16'd14, 16'd14, 16'd136, 16'd136, 16'd80};
            3'd3: row = '{16'd100, 16'd100, 16'd20, 16'd20, 16'd310, 16'd310, 16'd140};
            3'd4: row = '{16'd200, 16'd200, 16'd25, 16'd25, 16'd450, 16'd800, 16'd300};
            default: row = '{16'd1000, 16'd500, 16'd25, 16'd25, 16'd1450, 16'd5000,
                             16'd2000};
        endcase
        return row[c];
    endfunction

    function automatic logic [15:0] preset_total(input logic [PR_W-1:0] p);
        case (p)
            3'd0: return 16'd50;
            3'd1: return 16'd300;
            3'd2: return 16'd500;
            3'd3: return 16'd1000;
            3'd4: return 16'd2000;
            default: return 16'd10000;
        endcase
    endfunction

endpackage

// File: src/loss_adaptive_bandwidth_split.sv
// Tick, unused op or unchanged evaluate: decode state, then output state with result valid.
// Reload or fraction change: decode, a multiply with reciprocal divide by 10, a preset
// search, then per channel a setup state and a shared restoring divider at one quotient
// bit a cycle, 32 bits.
// One request at a time; ready is low until the result is taken, then high again.
// Synchronous active-low reset: fraction 10, rate, counter, budgets 0, regs 256, 5000, 48, 8.
module loss_adaptive_bandwidth_split (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [15:0]  s_axis_tdata,   // loss_sixteenths[10:0]
    input  logic [1:0]   s_axis_tuser,   // operation[1:0]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [151:0] m_axis_tdata,   // resend, land, wind, cloud, task, texture,
                                         // asset, total, current (16 each), fraction[147:144]
    output logic         m_axis_tuser,   // budgets_changed
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_index,
    input  logic [15:0]  i_cfg_data
);
    localparam int NC = labs_pkg::NUM_CHANNELS;
    localparam int NP = labs_pkg::NUM_PRESETS;
    localparam int CW = labs_pkg::CH_W;
    localparam int PW = labs_pkg::PR_W;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001, S_DEC  = 7'b0000010, S_MUL  = 7'b0000100,
        S_SRCH = 7'b0001000, S_CHAN = 7'b0010000, S_DIV  = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state r_state;
    logic [15:0] r_max_bw, r_period;
    logic [10:0] r_tighten, r_ease;
    logic [3:0]  r_frac;
    logic [15:0] r_rate, r_cnt;
    logic [15:0] r_bud [NC];
    logic [1:0]  r_op;
    logic [10:0] r_loss;
    logic        r_chg;
    logic [PW-1:0] r_idx;
    logic [CW-1:0] r_ch;
    logic [4:0]  r_bit;
    logic [31:0] r_num;
    logic [31:0] r_quo;
    logic [31:0] r_rem;
    logic [15:0] r_span;
    logic [PW-1:0] r_lo, r_hi;
    logic        r_ext;

    logic [15:0] w_bw, w_clr;
    logic [19:0] w_prod;
    logic [32:0] w_trial;
    logic [15:0] w_tot;
    logic [PW-1:0] w_base;
    logic        w_tighten, w_ease;

    assign w_bw = (r_max_bw < labs_pkg::RATE_MIN) ? labs_pkg::RATE_MIN :
                  (r_max_bw > labs_pkg::RATE_MAX) ? labs_pkg::RATE_MAX : r_max_bw;
    assign w_clr = (r_rate < labs_pkg::RATE_MIN) ? labs_pkg::RATE_MIN :
                   (r_rate > labs_pkg::RATE_MAX) ? labs_pkg::RATE_MAX : r_rate;
    assign w_prod = w_bw * r_frac;
    assign w_trial = {r_rem, r_num[31]} - {17'd0, r_span};
    assign w_base = r_ext ? r_hi : r_lo;
    assign w_tighten = (r_loss > r_tighten) && (r_frac > labs_pkg::FRAC_MIN)
                       && (r_rate > labs_pkg::RATE_MIN);
    assign w_ease = (r_loss <= r_tighten) && (r_loss <= r_ease)
                    && (r_frac < labs_pkg::FRAC_MAX) && (r_rate < labs_pkg::RATE_MAX);

    always_comb begin
        w_tot = '0;
        for (int c = 0; c < NC; c++) w_tot = w_tot + r_bud[c];
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT);
    assign m_axis_tuser  = r_chg;
    always_comb begin
        for (int c = 0; c < NC; c++) m_axis_tdata[16*c +: 16] = r_bud[c];
        m_axis_tdata[16*NC +: 16]     = w_tot;
        m_axis_tdata[16*NC+16 +: 16]  = r_rate;
        m_axis_tdata[16*NC+32 +: 4]   = r_frac;
        m_axis_tdata[151:16*NC+36]    = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_max_bw  <= 16'd256;
            r_period  <= 16'd5000;
            r_tighten <= 11'd48;
            r_ease    <= 11'd8;
            r_frac    <= labs_pkg::FRAC_RST;
            r_rate    <= '0;
            r_cnt     <= '0;
            r_chg     <= 1'b0;
            for (int c = 0; c < NC; c++) r_bud[c] <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    labs_pkg::CFG_MAX_BW:  r_max_bw  <= i_cfg_data;
                    labs_pkg::CFG_PERIOD:  r_period  <= i_cfg_data;
                    labs_pkg::CFG_TIGHTEN: r_tighten <= i_cfg_data[10:0];
                    labs_pkg::CFG_EASE:    r_ease    <= i_cfg_data[10:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    r_op   <= s_axis_tuser;
                    r_loss <= s_axis_tdata[10:0];
                    if (s_axis_tvalid) r_state <= S_DEC;
                end
                S_DEC: begin
                    if (r_op == labs_pkg::OP_RELOAD) begin
                        r_frac  <= labs_pkg::FRAC_MAX;
                        r_chg   <= 1'b1;
                        r_state <= S_MUL;
                    end else if (r_op == labs_pkg::OP_EVAL && r_cnt >= r_period) begin
                        r_cnt <= '0;
                        if (w_tighten) begin
                            r_frac  <= r_frac - 4'd1;
                            r_chg   <= 1'b1;
                            r_state <= S_MUL;
                        end else if (w_ease) begin
                            r_frac  <= r_frac + 4'd1;
                            r_chg   <= 1'b1;
                            r_state <= S_MUL;
                        end else begin
                            r_chg   <= 1'b0;
                            r_state <= S_OUT;
                        end
                    end else begin
                        if (r_op == labs_pkg::OP_TICK && r_cnt != 16'hFFFF)
                            r_cnt <= r_cnt + 16'd1;
                        r_chg   <= 1'b0;
                        r_state <= S_OUT;
                    end
                end
                S_MUL: begin
                    // divide by 10: (x * 838861) >> 23 is exact for x < 2^20
                    r_rate  <= 16'((44'(w_prod) * 44'd838861) >> 23);
                    r_idx   <= '0;
                    r_state <= S_SRCH;
                end
                S_SRCH: begin
                    if (labs_pkg::preset_total(r_idx) > w_clr || r_idx == PW'(NP)) begin
                        r_ch <= '0;
                        if (r_idx == '0) begin
                            for (int c = 0; c < NC; c++)
                                r_bud[c] <= labs_pkg::preset_val('0, CW'(c));
                            r_state <= S_OUT;
                        end else begin
                            r_ext <= (r_idx == PW'(NP));
                            r_lo  <= (r_idx == PW'(NP)) ? PW'(NP-2) : r_idx - 1'b1;
                            r_hi  <= (r_idx == PW'(NP)) ? PW'(NP-1) : r_idx;
                            r_state <= S_CHAN;
                        end
                    end else r_idx <= r_idx + 1'b1;
                end
                S_CHAN: begin
                    r_span <= labs_pkg::preset_total(r_hi) - labs_pkg::preset_total(r_lo);
                    if (labs_pkg::preset_val(r_hi, r_ch) >= labs_pkg::preset_val(r_lo, r_ch))
                        r_num <= (labs_pkg::preset_val(r_hi, r_ch)
                                  - labs_pkg::preset_val(r_lo, r_ch))
                                 * (w_clr - labs_pkg::preset_total(w_base));
                    else
                        r_num <= '0;
                    r_rem <= '0;
                    r_quo <= '0;
                    r_bit <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_trial[32]) begin
                        r_rem <= {r_rem[30:0], r_num[31]};
                        r_quo <= {r_quo[30:0], 1'b0};
                    end else begin
                        r_rem <= w_trial[31:0];
                        r_quo <= {r_quo[30:0], 1'b1};
                    end
                    r_num <= {r_num[30:0], 1'b0};
                    r_bit <= r_bit + 5'd1;
                    if (r_bit == 5'd31) begin
                        r_bud[r_ch] <= labs_pkg::preset_val(w_base, r_ch)
                                       + {r_quo[14:0], ~w_trial[32]};
                        if (r_ch == CW'(NC-1)) r_state <= S_OUT;
                        else begin
                            r_ch <= r_ch + 1'b1;
                            r_state <= S_CHAN;
                        end
                    end
                end
                S_OUT: begin
                    if (m_axis_tready) r_state <= S_IDLE;
                end
                default: ;
            endcase
        end
    end
endmodule

// File: test/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic             chg;
        logic [3:0]       frac;
        logic [8:0][15:0] f;
    } t_budget_rec;

    localparam int WATCHDOG_LIMIT = 5000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [15:0]  s_axis_tdata = '0;
    logic [1:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [151:0] m_axis_tdata;
    logic         m_axis_tuser;
    logic         i_cfg_we = 1'b0;
    logic [1:0]   i_cfg_index = '0;
    logic [15:0]  i_cfg_data = '0;

    loss_adaptive_bandwidth_split dut (.*);

    always #5 i_clk = ~i_clk;

    // shadow of the block
    int unsigned ceil_kbps, period_ticks, tight_lvl, ease_lvl;
    int unsigned frac_q, rate_q, tick_cnt;
    int unsigned budget_q [labs_pkg::NUM_CHANNELS];
    int          preset_tab [labs_pkg::NUM_PRESETS][labs_pkg::NUM_CHANNELS] = '{
        '{5, 10, 3, 3, 10, 10, 9},
        '{30, 40, 9, 9, 86, 86, 40},
        '{50, 70, 14, 14, 136, 136, 80},
        '{100, 100, 20, 20, 310, 310, 140},
        '{200, 200, 25, 25, 450, 800, 300},
        '{1000, 500, 25, 25, 1450, 5000, 2000}};

    logic [12:0]  req_q [$];
    t_budget_rec  budget_exp_q [$];
    int           fails = 0;
    int           tx_gap = 0, rx_stall = 0, rx_hold = 0, rx_count = 0, idle_cycles = 0;
    bit           quiet = 0;
    string        field_name [9] = '{"resend", "land", "wind", "cloud", "task", "texture",
                                     "asset", "total", "current"};

    function automatic int unsigned clamp_kbps(input int unsigned r);
        if (r < labs_pkg::RATE_MIN) return labs_pkg::RATE_MIN;
        if (r > labs_pkg::RATE_MAX) return labs_pkg::RATE_MAX;
        return r;
    endfunction

    function automatic int preset_sum(input int p);
        int s;
        s = 0;
        for (int c = 0; c < labs_pkg::NUM_CHANNELS; c++) s += preset_tab[p][c];
        return s;
    endfunction

    task automatic split_budgets(input int unsigned kbps);
        int     r, i, lo, hi, base;
        longint over, span, d, add;
        r = clamp_kbps(kbps);
        i = 0;
        while (i < labs_pkg::NUM_PRESETS && preset_sum(i) <= r) i++;
        if (i == 0) begin
            for (int c = 0; c < labs_pkg::NUM_CHANNELS; c++) budget_q[c] = preset_tab[0][c];
        end else begin
            lo = (i == labs_pkg::NUM_PRESETS) ? labs_pkg::NUM_PRESETS - 2 : i - 1;
            hi = lo + 1;
            span = preset_sum(hi) - preset_sum(lo);
            over = r - preset_sum(i == labs_pkg::NUM_PRESETS ? hi : lo);
            for (int c = 0; c < labs_pkg::NUM_CHANNELS; c++) begin
                base = (i == labs_pkg::NUM_PRESETS) ? preset_tab[hi][c] : preset_tab[lo][c];
                d = preset_tab[hi][c] - preset_tab[lo][c];
                add = (span != 0 && d >= 0) ? (d * over) / span : 0;
                budget_q[c] = 32'((base + add) & 16'hFFFF);
            end
        end
    endtask

    task automatic set_rate();
        rate_q = ((clamp_kbps(ceil_kbps) * frac_q) / 10) & 16'hFFFF;
        split_budgets(rate_q);
    endtask

    task automatic predict_budgets(input logic [1:0] op, input logic [10:0] loss_in,
                                   output t_budget_rec rec);
        int unsigned loss, tot;
        bit          chg;
        loss = loss_in;
        chg = 0;
        tot = 0;
        if (op == labs_pkg::OP_RELOAD) begin
            frac_q = labs_pkg::FRAC_MAX;
            set_rate();
            chg = 1;
        end else if (op == labs_pkg::OP_TICK) begin
            if (tick_cnt < 16'hFFFF) tick_cnt++;
        end else if (op == labs_pkg::OP_EVAL && tick_cnt >= period_ticks) begin
            tick_cnt = 0;
            if (loss > tight_lvl) begin
                if (frac_q > labs_pkg::FRAC_MIN && rate_q > labs_pkg::RATE_MIN) begin
                    frac_q--;
                    set_rate();
                    chg = 1;
                end
            end else if (loss <= ease_lvl) begin
                if (frac_q < labs_pkg::FRAC_MAX && rate_q < labs_pkg::RATE_MAX) begin
                    frac_q++;
                    set_rate();
                    chg = 1;
                end
            end
        end
        for (int c = 0; c < labs_pkg::NUM_CHANNELS; c++) begin
            rec.f[c] = 16'(budget_q[c]);
            tot += budget_q[c];
        end
        rec.f[7] = 16'(tot);
        rec.f[8] = 16'(rate_q);
        rec.frac = 4'(frac_q);
        rec.chg = chg;
    endtask

    task automatic report(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d", what, got, want);
        fails++;
    endtask

    // driver
    always @(posedge i_clk) begin
        t_budget_rec rec;
        logic [12:0] item;
        if (s_axis_tvalid && s_axis_tready) begin
            predict_budgets(s_axis_tuser, s_axis_tdata[10:0], rec);
            budget_exp_q.push_back(rec);
        end
        if (!s_axis_tvalid || s_axis_tready) begin
            if (tx_gap > 0) begin
                tx_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (req_q.size() > 0) begin
                item = req_q.pop_front();
                s_axis_tuser <= item[1:0];
                s_axis_tdata <= {5'd0, item[12:2]};
                s_axis_tvalid <= 1'b1;
                tx_gap = quiet ? 0 : $urandom_range(0, 8);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_budget_rec rec;
        logic        rdy;
        rdy = 1'b1;
        if (m_axis_tvalid && m_axis_tready) begin
            rx_count++;
            if (budget_exp_q.size() == 0) begin
                report("unexpected result", 0, 0);
            end else begin
                rec = budget_exp_q.pop_front();
                for (int k = 0; k < 9; k++)
                    if (m_axis_tdata[16*k +: 16] !== rec.f[k])
                        report(field_name[k], m_axis_tdata[16*k +: 16], rec.f[k]);
                if (m_axis_tdata[147:144] !== rec.frac)
                    report("fraction", m_axis_tdata[147:144], rec.frac);
                if (m_axis_tuser !== rec.chg)
                    report("budgets_changed", m_axis_tuser, rec.chg);
            end
            rx_stall = quiet ? 0 : $urandom_range(0, 8);
            if (rx_count == 150) rx_hold = 600;
        end
        if (rx_hold > 0) begin
            rx_hold--;
            rdy = 1'b0;
        end else if (rx_stall > 0) begin
            rx_stall--;
            rdy = 1'b0;
        end
        m_axis_tready <= rdy;
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        case (idx)
            labs_pkg::CFG_MAX_BW:  ceil_kbps = val;
            labs_pkg::CFG_PERIOD:  period_ticks = val;
            labs_pkg::CFG_TIGHTEN: tight_lvl = val[10:0];
            labs_pkg::CFG_EASE:    ease_lvl = val[10:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drained();
        while (req_q.size() > 0 || budget_exp_q.size() > 0 || s_axis_tvalid)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic push_req(input logic [1:0] op, input int unsigned loss);
        req_q.push_back({loss[10:0], op});
    endtask

    task automatic configure(input int unsigned bw, input int unsigned per,
                             input int unsigned tl, input int unsigned el);
        wait_drained();
        write_reg(labs_pkg::CFG_MAX_BW, 16'(bw));
        write_reg(labs_pkg::CFG_PERIOD, 16'(per));
        write_reg(labs_pkg::CFG_TIGHTEN, 16'(tl));
        write_reg(labs_pkg::CFG_EASE, 16'(el));
    endtask

    function automatic int unsigned pick_loss();
        int unsigned v;
        case ($urandom_range(0, 6))
            0: v = 0;
            1: v = ease_lvl;
            2: v = ease_lvl + 1;
            3: v = tight_lvl;
            4: v = tight_lvl + 1;
            5: v = 1600;
            default: v = $urandom_range(0, 1600);
        endcase
        return (v > 1600) ? 1600 : v;
    endfunction

    task automatic random_reqs(input int n);
        int cnt, k;
        cnt = 0;
        while (cnt < n) begin
            if ($urandom_range(0, 99) < 85) begin
                k = period_ticks + $urandom_range(0, 2);
                if ($urandom_range(0, 5) == 0 && period_ticks > 0) k = period_ticks - 1;
                if (k > 10) k = 10;
                repeat (k) push_req(labs_pkg::OP_TICK, $urandom_range(0, 1600));
                if ($urandom_range(0, 15) == 0) push_req(labs_pkg::OP_RELOAD, pick_loss());
                else push_req(labs_pkg::OP_EVAL, pick_loss());
                cnt += k + 1;
            end else begin
                push_req(2'($urandom_range(0, 3)), $urandom_range(0, 1600));
                cnt++;
            end
        end
    endtask

    initial begin
        ceil_kbps = 256;
        period_ticks = 5000;
        tight_lvl = 48;
        ease_lvl = 8;
        frac_q = labs_pkg::FRAC_RST;
        rate_q = 0;
        tick_cnt = 0;
        for (int c = 0; c < labs_pkg::NUM_CHANNELS; c++) budget_q[c] = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset state, unused op, evaluate before the period has passed
        push_req(labs_pkg::OP_UNUSED, 11'h7FF);
        push_req(labs_pkg::OP_EVAL, 0);
        push_req(labs_pkg::OP_TICK, 1600);
        push_req(labs_pkg::OP_EVAL, 1600);
        push_req(labs_pkg::OP_RELOAD, 0);
        wait_drained();
        // ceiling clamp, repeated tightening, then easing
        configure(65535, 0, 0, 1600);
        push_req(labs_pkg::OP_RELOAD, 0);
        repeat (3) push_req(labs_pkg::OP_EVAL, 1600);
        push_req(labs_pkg::OP_EVAL, 1);
        push_req(labs_pkg::OP_EVAL, 0);
        push_req(labs_pkg::OP_EVAL, 0);
        wait_drained();
        configure(0, 1, 0, 0);
        push_req(labs_pkg::OP_RELOAD, 0);
        push_req(labs_pkg::OP_TICK, 0);
        push_req(labs_pkg::OP_EVAL, 1600);
        push_req(labs_pkg::OP_EVAL, 1600);
        push_req(labs_pkg::OP_TICK, 0);
        push_req(labs_pkg::OP_EVAL, 0);
        // ceiling rewritten, takes effect on the next change
        configure(32768, 1, 1600, 0);
        push_req(labs_pkg::OP_TICK, 0);
        push_req(labs_pkg::OP_EVAL, 800);
        push_req(labs_pkg::OP_TICK, 0);
        push_req(labs_pkg::OP_EVAL, 0);
        push_req(labs_pkg::OP_RELOAD, 0);

        configure(32768, 2, 48, 8);
        random_reqs(120);
        configure(256, 1, 1600, 0);
        random_reqs(80);
        quiet = 1;
        configure(5000, 3, 100, 20);
        random_reqs(100);
        quiet = 0;
        configure(1000, 0, 0, 0);
        random_reqs(100);
        configure(65535, 65535, 1600, 1600);
        random_reqs(30);
        repeat (3) begin
            configure($urandom_range(0, 65535), $urandom_range(0, 5),
                      $urandom_range(0, 1600), $urandom_range(0, 1600));
            random_reqs(130);
        end

        wait_drained();
        repeat (300) @(posedge i_clk);
        if (fails == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
